FILE: design/bds2x2_pkg.sv
package bds2x2_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int CH_W          = 8;
  localparam int NUM_CH        = 4;
  localparam int PAIR_W        = CH_W + 1;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int IMG_W_W       = 12;
  localparam int IMG_H_W       = 16;
  localparam int NCH_W         = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_idx_t;

  localparam logic [IMG_W_W-1:0] IMG_W_RST = 12'd2;
  localparam logic [IMG_H_W-1:0] IMG_H_RST = 16'd2;
  localparam logic [NCH_W-1:0]   NCH_RST   = 3'd4;

  typedef logic [CH_W-1:0]   pix_t [NUM_CH];
  typedef logic [PAIR_W-1:0] pair_t [NUM_CH];

endpackage

FILE: design/box_downscale_2x2_top.sv
// The result of a 2x2 block passes through the input stage (with the line-buffer read) and
//   then the result register once the request on its last pixel is accepted.
// Throughput: one pixel per cycle unless the output stalls with both stages full; the line
//   buffer's registered read port sets the two-stage pipeline.
// Reset (synchronous, rst_n low): counters, held pixel, pipeline valids and configuration
//   registers return to their reset values; pipeline data and the line buffer are not cleared.
module box_downscale_2x2_top
  import bds2x2_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CH_W-1:0]       in_ch0,
  input  logic [CH_W-1:0]       in_ch1,
  input  logic [CH_W-1:0]       in_ch2,
  input  logic [CH_W-1:0]       in_ch3,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CH_W-1:0]       out_ch0,
  output logic [CH_W-1:0]       out_ch1,
  output logic [CH_W-1:0]       out_ch2,
  output logic [CH_W-1:0]       out_ch3,
  output logic                  out_frame_end
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int AW    = CW - 1;
  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int EW    = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;
  localparam int RAM_W = NUM_CH * PAIR_W;

  logic [IMG_W_W-1:0] img_w_r;
  logic [IMG_H_W-1:0] img_h_r;
  logic [NCH_W-1:0]   nch_r;

  logic [CW-1:0]      col_r, col_nxt;
  logic [IMG_H_W-1:0] row_r, row_nxt;
  pix_t               held_r, held_nxt;

  logic               s1_vld_r;
  pair_t              s1_hp_r;
  logic               s1_fe_r;

  logic               out_vld_r;
  pix_t               out_px_r;
  logic               out_fe_r;

  logic               in_acc, s1_adv;
  logic [EW-1:0]      w_cfg, w_max, w_eff, w_even, col_x, col_e_x;
  logic [CW-1:0]      col_e;
  logic [IMG_H_W-1:0] h_eff, h_even, row_e;
  logic               col_last, row_last, in_span, frame_end;
  pix_t               px;
  pair_t              hp;
  logic [3:0]         ch_use;

  logic               ram_we, ram_re;
  logic [AW-1:0]      slot;
  logic [RAM_W-1:0]   ram_wdata, ram_rdata;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= IMG_W_RST;
      img_h_r <= IMG_H_RST;
      nch_r   <= NCH_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:   img_w_r <= cfg_data[IMG_W_W-1:0];
        CFG_IMAGE_HEIGHT:  img_h_r <= cfg_data[IMG_H_W-1:0];
        CFG_CHANNEL_COUNT: nch_r   <= cfg_data[NCH_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign s1_adv   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || !out_vld_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  // effective geometry and position
  always_comb begin
    w_cfg = EW'(img_w_r);
    w_max = EW'(MAX_WIDTH);
    if (w_cfg < EW'(2)) begin
      w_eff = EW'(2);
    end else if (w_cfg > w_max) begin
      w_eff = w_max;
    end else begin
      w_eff = w_cfg;
    end
    w_even  = {w_eff[EW-1:1], 1'b0};
    col_x   = EW'(col_r);
    col_e_x = (col_x >= w_eff) ? '0 : col_x;
    col_e   = col_e_x[CW-1:0];

    h_eff  = (img_h_r < IMG_H_W'(2)) ? IMG_H_W'(2) : img_h_r;
    h_even = {h_eff[IMG_H_W-1:1], 1'b0};
    row_e  = (row_r >= h_eff) ? '0 : row_r;

    col_last  = (col_e_x + EW'(1)) >= w_eff;
    row_last  = ({1'b0, row_e} + 17'd1) >= {1'b0, h_eff};
    in_span   = col_e_x < w_even;
    frame_end = (row_e == h_even - IMG_H_W'(1)) && (col_e_x == w_even - EW'(1));

    col_nxt = col_last ? '0 : col_e + CW'(1);
    row_nxt = col_last ? (row_last ? '0 : row_e + IMG_H_W'(1)) : row_e;
  end

  // channel masking and pair sums
  always_comb begin
    ch_use[0] = 1'b1;
    ch_use[1] = nch_r > NCH_W'(1);
    ch_use[2] = nch_r > NCH_W'(2);
    ch_use[3] = nch_r > NCH_W'(3);
    px[0] = in_ch0;
    px[1] = ch_use[1] ? in_ch1 : '0;
    px[2] = ch_use[2] ? in_ch2 : '0;
    px[3] = ch_use[3] ? in_ch3 : '0;
    for (int k = 0; k < NUM_CH; k++) begin
      hp[k]                     = {1'b0, held_r[k]} + {1'b0, px[k]};
      ram_wdata[k*PAIR_W +: PAIR_W] = hp[k];
    end
    held_nxt = held_r;
    if (in_span && !col_e[0]) begin
      held_nxt = px;
    end
  end

  assign slot   = col_e[CW-1:1];
  assign ram_we = in_acc && in_span && col_e[0] && !row_e[0];
  assign ram_re = in_acc && in_span && col_e[0] && row_e[0];

  bds2x2_ram #(
    .WIDTH (RAM_W),
    .DEPTH (DEPTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  // position, held pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      for (int k = 0; k < NUM_CH; k++) begin
        held_r[k] <= '0;
      end
    end else if (in_acc) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      held_r <= held_nxt;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (ram_re) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      s1_hp_r <= hp;
      s1_fe_r <= frame_end;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    logic [PAIR_W:0] sum;
    if (s1_adv) begin
      for (int k = 0; k < NUM_CH; k++) begin
        sum = {1'b0, ram_rdata[k*PAIR_W +: PAIR_W]} + {1'b0, s1_hp_r[k]};
        out_px_r[k] <= sum[PAIR_W:2];
      end
      out_fe_r <= s1_fe_r;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_ch0       = out_px_r[0];
  assign out_ch1       = out_px_r[1];
  assign out_ch2       = out_px_r[2];
  assign out_ch3       = out_px_r[3];
  assign out_frame_end = out_fe_r;

  a_ram_rw_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("line buffer written and read in one cycle");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_vld_r && out_vld_r))
    else $error("input stalled with room in the pipeline");

  a_read_loads_s1: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> s1_vld_r)
    else $error("line buffer read without input stage valid");

  a_adv_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_vld_r)
    else $error("input stage advanced without result valid");

endmodule

FILE: design/bds2x2_ram.sv
module bds2x2_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: tb/tb_box_downscale_2x2_top.sv
`timescale 1ns / 1ps

module tb_box_downscale_2x2_top;
  import bds2x2_pkg::*;

  typedef logic [NUM_CH-1:0][CH_W-1:0] pix4_t;

  typedef struct packed {
    pix4_t ch;
    logic  frame_end;
  } avg_t;

  typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    cfg_idx_t              idx;
    logic [CFG_DATA_W-1:0] val;
    pix4_t                 px;
    logic                  typed;
    avg_t                  want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CH_W-1:0]       in_ch0 = '0;
  logic [CH_W-1:0]       in_ch1 = '0;
  logic [CH_W-1:0]       in_ch2 = '0;
  logic [CH_W-1:0]       in_ch3 = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CH_W-1:0]       out_ch0;
  logic [CH_W-1:0]       out_ch1;
  logic [CH_W-1:0]       out_ch2;
  logic [CH_W-1:0]       out_ch3;
  logic                  out_frame_end;

  box_downscale_2x2_top dut (.*);

  // mirror of the block's registers and line state
  logic [IMG_W_W-1:0] reg_width = IMG_W_RST;
  logic [IMG_H_W-1:0] reg_height = IMG_H_RST;
  logic [NCH_W-1:0]   reg_chans = NCH_RST;
  logic [PAIR_W-1:0]  line_sums [MAX_WIDTH_DEF/2][NUM_CH];
  pix4_t              left_px = '0;
  int unsigned        col_q = 0;
  int unsigned        row_q = 0;

  avg_t pending_averages [$];
  int   bad_results = 0;
  bit   steady = 1'b0;

  dir_row_t dir_steps [32] = '{
    '{ROW_PIXEL, CFG_UNUSED, 16'h0, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_PIXEL, CFG_UNUSED, 16'h0, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_PIXEL, CFG_UNUSED, 16'h0, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_PIXEL, CFG_UNUSED, 16'h0, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 1'b1}},
    // truncation: sums of 3 and 1019 and 513
    '{ROW_PIXEL, CFG_UNUSED, 16'h0, 32'h8000_FF01, 1'b0, '0},
    '{ROW_PIXEL, CFG_UNUSED, 16'h0, 32'h8000_FF01, 1'b0, '0},
    '{ROW_PIXEL, CFG_UNUSED, 16'h0, 32'h8000_FF01, 1'b0, '0},
    '{ROW_PIXEL, CFG_UNUSED, 16'h0, 32'h8103_FE00, 1'b1, '{32'h8000_FE00, 1'b1}},
    // zero channels taken as one
    '{ROW_REG, CFG_CHANNEL_COUNT, 16'h0000, '0, 1'b0, '0},
    '{ROW_PIXEL, CFG_UNUSED, 16'h0, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_PIXEL, CFG_UNUSED, 16'h0, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_PIXEL, CFG_UNUSED, 16'h0, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_PIXEL, CFG_UNUSED, 16'h0, 32'hFFFF_FFFF, 1'b1, '{32'h0000_00FF, 1'b1}},
    // seven channels taken as four, odd 3x3 frame, write to the spare index
    '{ROW_REG, CFG_CHANNEL_COUNT, 16'hFFFF, '0, 1'b0, '0},
    '{ROW_REG, CFG_IMAGE_WIDTH, 16'hF003, '0, 1'b0, '0},
    '{ROW_REG, CFG_IMAGE_HEIGHT, 16'h0003, '0, 1'b0, '0},
    '{ROW_REG, CFG_UNUSED, 16'hA5A5, '0, 1'b0, '0},
    '{ROW_PIXEL, CFG_UNUSED, 16'h0, 32'h0123_4567, 1'b0, '0},
    '{ROW_PIXEL, CFG_UNUSED, 16'h0, 32'h89AB_CDEF, 1'b0, '0},
    '{ROW_PIXEL, CFG_UNUSED, 16'h0, 32'hFEDC_BA98, 1'b0, '0},
    '{ROW_PIXEL, CFG_UNUSED, 16'h0, 32'h7654_3210, 1'b0, '0},
    '{ROW_PIXEL, CFG_UNUSED, 16'h0, 32'hA5A5_5A5A, 1'b0, '0},
    '{ROW_PIXEL, CFG_UNUSED, 16'h0, 32'h0F0F_F0F0, 1'b0, '0},
    '{ROW_PIXEL, CFG_UNUSED, 16'h0, 32'h3C3C_C3C3, 1'b0, '0},
    '{ROW_PIXEL, CFG_UNUSED, 16'h0, 32'h9999_6666, 1'b0, '0},
    '{ROW_PIXEL, CFG_UNUSED, 16'h0, 32'h5AC3_3CA5, 1'b0, '0},
    // width and height below range taken as two
    '{ROW_REG, CFG_IMAGE_WIDTH, 16'h0000, '0, 1'b0, '0},
    '{ROW_REG, CFG_IMAGE_HEIGHT, 16'h0001, '0, 1'b0, '0},
    '{ROW_PIXEL, CFG_UNUSED, 16'h0, 32'hC8C8_C8C8, 1'b0, '0},
    '{ROW_PIXEL, CFG_UNUSED, 16'h0, 32'hC8C8_C8C8, 1'b0, '0},
    '{ROW_PIXEL, CFG_UNUSED, 16'h0, 32'hC8C8_C8C8, 1'b0, '0},
    '{ROW_PIXEL, CFG_UNUSED, 16'h0, 32'hC8C8_C8C8, 1'b1, '{32'hC8C8_C8C8, 1'b1}}
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit average_block(input pix4_t raw, output avg_t res);
    int unsigned w, h, n, c, r, slot, s, k;
    pix4_t       px;
    bit          made;
    made = 1'b0;
    res = '0;
    w = (reg_width < 2) ? 2 : ((reg_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : reg_width);
    h = (reg_height < 2) ? 2 : reg_height;
    n = (reg_chans < 1) ? 1 : ((reg_chans > NUM_CH) ? NUM_CH : reg_chans);
    if (col_q >= w) col_q = 0;
    if (row_q >= h) row_q = 0;
    c = col_q;
    r = row_q;
    for (k = 0; k < NUM_CH; k++) px[k] = (k < n) ? raw[k] : '0;
    slot = (c >> 1) % (MAX_WIDTH_DEF / 2);
    if (c < (w & ~32'd1)) begin
      if (!c[0]) begin
        left_px = px;
      end else if (!r[0]) begin
        for (k = 0; k < NUM_CH; k++) line_sums[slot][k] = left_px[k] + px[k];
      end else begin
        for (k = 0; k < NUM_CH; k++) begin
          s = line_sums[slot][k] + left_px[k] + px[k];
          res.ch[k] = CH_W'(s >> 2);
        end
        res.frame_end = (r == (h & ~32'd1) - 1) && (c == (w & ~32'd1) - 1);
        made = 1'b1;
      end
    end
    if (c + 1 >= w) begin
      col_q = 0;
      row_q = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_q = c + 1;
    end
    return made;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_reg_value(input cfg_idx_t idx);
    logic [CFG_DATA_W-1:0] v;
    v = CFG_DATA_W'($urandom());
    case (idx)
      CFG_IMAGE_WIDTH: begin
        v[IMG_W_W-1:0] = ($urandom_range(9) == 0) ? IMG_W_W'($urandom_range(0, 1)) :
                                                    IMG_W_W'($urandom_range(2, 20));
      end
      CFG_IMAGE_HEIGHT: begin
        v = CFG_DATA_W'($urandom_range(0, 9));
      end
      CFG_CHANNEL_COUNT: begin
        v[NCH_W-1:0] = NCH_W'($urandom_range(0, 7));
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      bad_results++;
    end
  endfunction

  function automatic void queue_average(input avg_t a);
    pending_averages = {pending_averages, a};
  endfunction

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 8);
  end

  always @(posedge clk) begin : result_check
    avg_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got.ch = {out_ch3, out_ch2, out_ch1, out_ch0};
      got.frame_end = out_frame_end;
      if (pending_averages.size() == 0) begin
        $error("out_valid with no pending average");
        bad_results++;
      end else begin
        want = pending_averages.pop_front();
        check_field("out_ch0", want.ch[0], got.ch[0]);
        check_field("out_ch1", want.ch[1], got.ch[1]);
        check_field("out_ch2", want.ch[2], got.ch[2]);
        check_field("out_ch3", want.ch[3], got.ch[3]);
        check_field("out_frame_end", want.frame_end, got.frame_end);
      end
    end
  end

  task automatic send_pixel(input pix4_t px, input bit typed, input avg_t want);
    avg_t res;
    if (!steady && $urandom_range(99) < 3) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch0 <= px[0];
    in_ch1 <= px[1];
    in_ch2 <= px[2];
    in_ch3 <= px[3];
    do @(posedge clk); while (!in_ready);
    if (average_block(px, res)) queue_average(typed ? want : res);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_averages.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH: reg_width = val[IMG_W_W-1:0];
      CFG_IMAGE_HEIGHT: reg_height = val[IMG_H_W-1:0];
      CFG_CHANNEL_COUNT: reg_chans = val[NCH_W-1:0];
      default: ;
    endcase
  endtask

  // runs to the next frame boundary; reshaping only at the start of an even row
  task automatic run_frame(input bit reshape, inout int unsigned sent);
    cfg_idx_t pick;
    do begin
      send_pixel($urandom(), 1'b0, '0);
      sent++;
      if (sent == 5 || $urandom_range(299) == 0) drain_results();
      if (reshape && col_q == 0 && !row_q[0] && row_q != 0 && $urandom_range(5) == 0) begin
        pick = cfg_idx_t'($urandom_range(0, 2));
        write_reg(pick, rand_reg_value(pick));
      end
    end while (col_q != 0 || row_q != 0);
  endtask

  initial begin : stimulus
    int unsigned sent, other;
    sent = 0;
    other = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_steps[i]) begin
      if (dir_steps[i].kind == ROW_REG) write_reg(dir_steps[i].idx, dir_steps[i].val);
      else send_pixel(dir_steps[i].px, dir_steps[i].typed, dir_steps[i].want);
    end

    // tallest height, cut short by shrinking it at an even row
    write_reg(CFG_IMAGE_WIDTH, 16'h0004);
    write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
    write_reg(CFG_CHANNEL_COUNT, rand_reg_value(CFG_CHANNEL_COUNT));
    repeat (32) send_pixel($urandom(), 1'b0, '0);
    write_reg(CFG_IMAGE_HEIGHT, 16'h0002);
    run_frame(1'b0, other);

    // long row, no random idling on either side
    steady = 1'b1;
    write_reg(CFG_IMAGE_WIDTH, 16'h0100);
    write_reg(CFG_IMAGE_HEIGHT, 16'h0002);
    write_reg(CFG_CHANNEL_COUNT, 16'h0004);
    run_frame(1'b0, sent);
    steady = 1'b0;

    while (sent < 1600) begin
      write_reg(CFG_IMAGE_WIDTH, rand_reg_value(CFG_IMAGE_WIDTH));
      write_reg(CFG_IMAGE_HEIGHT, rand_reg_value(CFG_IMAGE_HEIGHT));
      write_reg(CFG_CHANNEL_COUNT, rand_reg_value(CFG_CHANNEL_COUNT));
      repeat ($urandom_range(1, 3)) run_frame(1'b1, sent);
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (bad_results == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
design/bds2x2_pkg.sv
design/bds2x2_ram.sv
design/box_downscale_2x2_top.sv
tb/tb_box_downscale_2x2_top.sv
